/* rtl/core/ddm_pkg.sv */
// ddm_pkg: shared widths, constants and decimal helpers for the decimal digit multiplier.
// No dependencies.

package ddm_pkg;

  localparam int OPERAND_W      = 31;  // binary operand width
  localparam int DIGIT_W        = 4;   // one decimal digit
  localparam int PD_W           = 5;   // product accumulator entry
  localparam int SUM_W          = 8;   // digit product plus entry plus carry
  localparam int DEF_MAX_DIGITS = 10;
  localparam int RADIX          = 10;
  localparam int IN_TDATA_W     = 64;
  localparam int OUT_TDATA_W    = 8;

  // Quotient by ten of an 8-bit value; every threshold compare is independent.
  function automatic logic [PD_W-1:0] div10_u8(input logic [SUM_W-1:0] v);
    logic [PD_W-1:0] q;
    q = '0;
    for (int k = 1; k <= 25; k++) begin
      if (v >= SUM_W'(k * RADIX)) q = PD_W'(k);
    end
    return q;
  endfunction

  function automatic logic [DIGIT_W-1:0] mod10_u8(input logic [SUM_W-1:0] v);
    logic [SUM_W-1:0] r;
    r = v - SUM_W'(div10_u8(v)) * SUM_W'(RADIX);
    return r[DIGIT_W-1:0];
  endfunction

endpackage

/* rtl/core/decimal_digit_multiplier_core.sv */
// decimal_digit_multiplier_core: schoolbook decimal multiply of two binary operands,
// product digits streamed out most significant first. Depends on ddm_pkg.
//
// Steps per word: binary to BCD conversion, digit load and product clear, then
//   multiply-accumulate (one digit pair a cycle through the product memory, except while
//   issue is held at a row end for the carry write), then leading-zero skip and digit
//   emission.
// One operand pair in flight; in_tready is high only between items.
// Reset clears control state only; the product memory is cleared by each item's load pass.

module decimal_digit_multiplier_core
  import ddm_pkg::*;
#(
  parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [30:0] operand_a, [61:31] operand_b
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [3:0] digit
  output logic                   out_tlast   // last_digit
);

  localparam int PROD_DIGITS = 2 * MAX_DIGITS;
  localparam int CW          = $clog2(MAX_DIGITS + 1);
  localparam int TW          = $clog2(PROD_DIGITS + 1);
  localparam int DAW         = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int PAW         = $clog2(PROD_DIGITS);
  localparam int BCD_W       = MAX_DIGITS * DIGIT_W;
  localparam int BW          = $clog2(OPERAND_W);

  typedef enum logic [2:0] {
    S_IDLE, S_CONV, S_COUNT, S_LOAD, S_MAC, S_EMIT_RD, S_EMIT_CHK, S_EMIT_OUT
  } state_t;

  state_t               state_r;
  logic [OPERAND_W-1:0] opa_r, opb_r;
  logic [BCD_W-1:0]     bcd_a_r, bcd_b_r;
  logic                 ovf_a_r, ovf_b_r;
  logic [BW-1:0]        bit_cnt_r;
  logic [CW-1:0]        na_r, nb_r;
  logic [TW-1:0]        total_r;
  logic [TW-1:0]        idx_r;
  logic [CW-1:0]        p_r, q_r;
  logic                 issue_act_r;
  logic                 s2_vld_r, s2_last_r;
  logic [PAW-1:0]       s2_addr_r;
  logic [CW-1:0]        s2_p_r;
  logic [PD_W-1:0]      carry_r;
  logic                 cw_vld_r;
  logic [PAW-1:0]       cw_addr_r;
  logic [PD_W-1:0]      cw_data_r;
  logic                 scan_r;
  logic                 out_valid_r, out_last_r;
  logic [DIGIT_W-1:0]   out_digit_r;

  // memories and registered read data
  logic [DIGIT_W-1:0] dig_a_mem [MAX_DIGITS];
  logic [DIGIT_W-1:0] dig_b_mem [MAX_DIGITS];
  logic [PD_W-1:0]    pd_mem    [PROD_DIGITS];
  logic [DIGIT_W-1:0] dig_a_rd_r, dig_b_rd_r;
  logic [PD_W-1:0]    pd_rd_r;

  logic [BCD_W-1:0]   bcd_a_adj, bcd_b_adj;
  logic [CW-1:0]      cnt_a, cnt_b;
  logic               dig_a_we, dig_b_we;
  logic [TW-1:0]      la_full, lb_full;
  logic               pd_we;
  logic [PAW-1:0]     pd_wa, pd_ra, mac_addr;
  logic [PD_W-1:0]    pd_wd;
  logic               issue_go, mac_done, emit_last;
  logic [SUM_W-1:0]   mac_sum;
  logic [PD_W-1:0]    mac_quo;
  logic [DIGIT_W-1:0] mac_rem;

  // double-dabble adjust: add 3 to every digit at 5 or more before the shift
  always_comb begin
    bcd_a_adj = bcd_a_r;
    bcd_b_adj = bcd_b_r;
    for (int k = 0; k < MAX_DIGITS; k++) begin
      if (bcd_a_r[k*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5))
        bcd_a_adj[k*DIGIT_W +: DIGIT_W] = bcd_a_r[k*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
      if (bcd_b_r[k*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5))
        bcd_b_adj[k*DIGIT_W +: DIGIT_W] = bcd_b_r[k*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
    end
  end

  // digit count: top nonzero digit, or full width if digits were shifted out
  always_comb begin
    cnt_a = '0;
    cnt_b = '0;
    for (int k = 0; k < MAX_DIGITS; k++) begin
      if (bcd_a_r[k*DIGIT_W +: DIGIT_W] != '0) cnt_a = CW'(k + 1);
      if (bcd_b_r[k*DIGIT_W +: DIGIT_W] != '0) cnt_b = CW'(k + 1);
    end
    if (ovf_a_r) cnt_a = CW'(MAX_DIGITS);
    if (ovf_b_r) cnt_b = CW'(MAX_DIGITS);
  end

  // load pass: least significant digit goes to the highest index
  assign dig_a_we = (state_r == S_LOAD) && (idx_r < TW'(na_r));
  assign dig_b_we = (state_r == S_LOAD) && (idx_r < TW'(nb_r));
  assign la_full  = TW'(na_r) - idx_r - TW'(1);
  assign lb_full  = TW'(nb_r) - idx_r - TW'(1);

  // multiply-accumulate datapath on the registered read data
  assign mac_sum  = SUM_W'({4'b0, dig_a_rd_r} * {4'b0, dig_b_rd_r})
                  + SUM_W'(pd_rd_r) + SUM_W'(carry_r);
  assign mac_quo  = div10_u8(mac_sum);
  assign mac_rem  = mod10_u8(mac_sum);
  assign mac_addr = PAW'(p_r) + PAW'(q_r) + PAW'(1);

  // hold issue at a row end so the carry write lands before the next row reads
  assign issue_go = (state_r == S_MAC) && issue_act_r && !(s2_vld_r && s2_last_r) && !cw_vld_r;
  assign mac_done = (state_r == S_MAC) && !issue_act_r && !s2_vld_r && !cw_vld_r;
  assign emit_last = (idx_r == TW'(total_r - TW'(1)));

  assign pd_ra = (state_r == S_MAC) ? mac_addr : idx_r[PAW-1:0];

  always_comb begin
    pd_we = 1'b0;
    pd_wa = idx_r[PAW-1:0];
    pd_wd = '0;
    priority if (state_r == S_LOAD) begin
      pd_we = 1'b1;
    end else if (s2_vld_r) begin
      pd_we = 1'b1;
      pd_wa = s2_addr_r;
      pd_wd = PD_W'(mac_rem);
    end else if (cw_vld_r) begin
      pd_we = 1'b1;
      pd_wa = cw_addr_r;
      pd_wd = cw_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (dig_a_we) dig_a_mem[la_full[DAW-1:0]] <= bcd_a_r[DIGIT_W-1:0];
    if (dig_b_we) dig_b_mem[lb_full[DAW-1:0]] <= bcd_b_r[DIGIT_W-1:0];
    dig_a_rd_r <= dig_a_mem[p_r[DAW-1:0]];
    dig_b_rd_r <= dig_b_mem[q_r[DAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (pd_we) pd_mem[pd_wa] <= pd_wd;
    pd_rd_r <= pd_mem[pd_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      issue_act_r <= 1'b0;
      s2_vld_r    <= 1'b0;
      cw_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      scan_r      <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            opa_r     <= in_tdata[OPERAND_W-1:0];
            opb_r     <= in_tdata[2*OPERAND_W-1:OPERAND_W];
            bcd_a_r   <= '0;
            bcd_b_r   <= '0;
            ovf_a_r   <= 1'b0;
            ovf_b_r   <= 1'b0;
            bit_cnt_r <= '0;
            state_r   <= S_CONV;
          end
        end
        S_CONV: begin
          bcd_a_r   <= {bcd_a_adj[BCD_W-2:0], opa_r[OPERAND_W-1]};
          bcd_b_r   <= {bcd_b_adj[BCD_W-2:0], opb_r[OPERAND_W-1]};
          ovf_a_r   <= ovf_a_r | bcd_a_adj[BCD_W-1];
          ovf_b_r   <= ovf_b_r | bcd_b_adj[BCD_W-1];
          opa_r     <= {opa_r[OPERAND_W-2:0], 1'b0};
          opb_r     <= {opb_r[OPERAND_W-2:0], 1'b0};
          bit_cnt_r <= bit_cnt_r + BW'(1);
          if (bit_cnt_r == BW'(OPERAND_W - 1)) state_r <= S_COUNT;
        end
        S_COUNT: begin
          na_r    <= cnt_a;
          nb_r    <= cnt_b;
          total_r <= TW'(cnt_a) + TW'(cnt_b);
          idx_r   <= '0;
          state_r <= S_LOAD;
        end
        S_LOAD: begin
          bcd_a_r <= bcd_a_r >> DIGIT_W;
          bcd_b_r <= bcd_b_r >> DIGIT_W;
          idx_r   <= idx_r + TW'(1);
          if (idx_r == TW'(PROD_DIGITS - 1)) begin
            p_r         <= na_r - CW'(1);
            q_r         <= nb_r - CW'(1);
            issue_act_r <= (na_r != '0) && (nb_r != '0);
            carry_r     <= '0;
            state_r     <= S_MAC;
          end
        end
        S_MAC: begin
          if (issue_go) begin
            s2_vld_r  <= 1'b1;
            s2_last_r <= (q_r == '0);
            s2_addr_r <= mac_addr;
            s2_p_r    <= p_r;
            if (q_r == '0) begin
              q_r <= nb_r - CW'(1);
              if (p_r == '0) issue_act_r <= 1'b0;
              else p_r <= p_r - CW'(1);
            end else begin
              q_r <= q_r - CW'(1);
            end
          end else begin
            s2_vld_r <= 1'b0;
          end
          if (s2_vld_r) begin
            carry_r   <= s2_last_r ? '0 : mac_quo;
            cw_vld_r  <= s2_last_r;
            cw_addr_r <= PAW'(s2_p_r);
            cw_data_r <= mac_quo;
          end else begin
            cw_vld_r <= 1'b0;
          end
          if (mac_done) begin
            idx_r <= '0;
            if (total_r == '0) begin
              // both operands without digits: product is a single zero
              out_valid_r <= 1'b1;
              out_digit_r <= '0;
              out_last_r  <= 1'b1;
              state_r     <= S_EMIT_OUT;
            end else begin
              scan_r  <= 1'b1;
              state_r <= S_EMIT_RD;
            end
          end
        end
        S_EMIT_RD: begin
          state_r <= S_EMIT_CHK;
        end
        S_EMIT_CHK: begin
          if (scan_r && (pd_rd_r == '0) && !emit_last) begin
            idx_r   <= idx_r + TW'(1);
            state_r <= S_EMIT_RD;
          end else begin
            scan_r      <= 1'b0;
            out_valid_r <= 1'b1;
            out_digit_r <= pd_rd_r[DIGIT_W-1:0];
            out_last_r  <= emit_last;
            state_r     <= S_EMIT_OUT;
          end
        end
        S_EMIT_OUT: begin
          if (out_tready) begin
            out_valid_r <= 1'b0;
            if (out_last_r) begin
              state_r <= S_IDLE;
            end else begin
              idx_r   <= idx_r + TW'(1);
              state_r <= S_EMIT_RD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - DIGIT_W){1'b0}}, out_digit_r};
  assign out_tlast  = out_last_r;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input accepted while a product digit is pending");

  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    cw_vld_r |-> !s2_vld_r)
    else $error("carry write collides with accumulate write");

  a_row_carry: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_vld_r && s2_last_r) |=> cw_vld_r)
    else $error("row end without carry write");

  a_decimal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[3:0] <= 4'd9))
    else $error("product digit out of decimal range");

endmodule
